// File: sv/sesi_pkg.sv
`timescale 1ns / 1ps
// sesi_pkg: shared types and constants for the sorted endpoint set
// depends on nothing

package sesi_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CountW      = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [5:0]  read_index;
  } sesi_in_t;

  typedef struct packed {
    logic [6:0]  entry_count;
    logic [31:0] read_value;
    logic [1:0]  values_added;
    logic        dropped;
  } sesi_out_t;

  typedef struct packed {
    logic load;
    logic place;
    logic sel_second;
    logic capture_read;
    logic clear;
    logic finish;
  } sesi_cmd_t;

  typedef struct packed {
    opcode_e op;
  } sesi_status_t;

endpackage

// File: sv/sesi_datapath.sv
`timescale 1ns / 1ps
// sesi_datapath: compare-and-shift cell chain, entry count and result register
// depends on sesi_pkg

module sesi_datapath import sesi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sesi_cmd_t    cmd_i,
  input  sesi_in_t     in_word_i,
  output sesi_status_t status_o,
  output sesi_out_t    out_word_o
);

  opcode_e            op_q;
  logic [31:0]        first_q, second_q;
  logic [5:0]         idx_q;
  logic [31:0]        cells_q [TABLE_DEPTH];
  logic [31:0]        cells_d [TABLE_DEPTH];
  logic [CountW-1:0]  count_q, count_d;
  logic [1:0]         added_q, added_d;
  logic               drop_q, drop_d;
  sesi_out_t          result_q;

  logic [31:0]            value;
  logic [TABLE_DEPTH-1:0] lt, eq, hit;
  logic                   present, full, do_shift;
  logic [31:0]            rd_value;

  assign value = cmd_i.sel_second ? second_q : first_q;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lt[i]  = (CountW'(i) < count_q) && (cells_q[i] < value);
      eq[i]  = (CountW'(i) < count_q) && (cells_q[i] == value);
      hit[i] = (int'(idx_q) == i) && (CountW'(i) < count_q);
    end
  end

  assign present  = |eq;
  assign full     = (count_q >= CountW'(TABLE_DEPTH));
  assign do_shift = cmd_i.place && !present && !full;

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rd_value = rd_value | (cells_q[i] & {32{hit[i]}});
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!do_shift || lt[i]) begin
        cells_d[i] = cells_q[i];
      end else if (i == 0) begin
        cells_d[i] = value;
      end else if (lt[(i == 0) ? 0 : i - 1]) begin
        cells_d[i] = value;
      end else begin
        cells_d[i] = cells_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    added_d = added_q;
    drop_d  = drop_q;
    if (cmd_i.load) begin
      added_d = '0;
      drop_d  = 1'b0;
    end
    if (do_shift) begin
      count_d = count_q + 1'b1;
      added_d = added_q + 1'b1;
    end
    if (cmd_i.place && !present && full) begin
      drop_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      added_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      added_q <= added_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_e'(in_word_i.opcode);
      first_q  <= in_word_i.first_value;
      second_q <= in_word_i.second_value;
      idx_q    <= in_word_i.read_index;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cells_q[i] <= cells_d[i];
    end
    if (cmd_i.finish) begin
      result_q.entry_count  <= 7'(count_d);
      result_q.read_value   <= cmd_i.capture_read ? rd_value : 32'd0;
      result_q.values_added <= added_d;
      result_q.dropped      <= drop_d;
    end
  end

  assign status_o.op = op_q;
  assign out_word_o  = result_q;

endmodule

// File: sv/sesi_ctrl.sv
`timescale 1ns / 1ps
// sesi_ctrl: sequencing state machine for one word at a time
// depends on sesi_pkg

module sesi_ctrl import sesi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  sesi_status_t status_i,
  output sesi_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_FIRST;
      ST_FIRST:  state_d = ST_SECOND;
      ST_SECOND: state_d = ST_RESP;
      ST_RESP:   if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_FIRST: begin
        cmd_o.place = (status_i.op == OP_INSERT);
      end
      ST_SECOND: begin
        cmd_o.place        = (status_i.op == OP_INSERT);
        cmd_o.sel_second   = 1'b1;
        cmd_o.capture_read = (status_i.op == OP_READ);
        cmd_o.clear        = (status_i.op == OP_CLEAR);
        cmd_o.finish       = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/sorted_endpoint_set_insert.sv
`timescale 1ns / 1ps
// sorted_endpoint_set_insert: top level, controller plus cell-chain datapath
// depends on sesi_pkg, sesi_ctrl, sesi_datapath
// sequence: ST_FIRST, ST_SECOND (result registered) and ST_RESP follow accept;
// no new word is taken until the result is taken; the two
// endpoints pass one after the other through the single compare-and-shift chain
// reset: entry count cleared, table contents undefined, no clearing pass

module sorted_endpoint_set_insert import sesi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sesi_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sesi_out_t out_word_o
);

  sesi_cmd_t    cmd;
  sesi_status_t status;

  sesi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sesi_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while a result is pending");

  a_gap_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o && !in_ready_o)
    else $error("result appeared too early");

  a_drop_limits_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.dropped) |-> (out_word_o.values_added != 2'd2))
    else $error("drop flagged with both endpoints added");

  a_insert_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.values_added != 2'd0) |-> (out_word_o.read_value == 32'd0))
    else $error("insert result carries read data");

endmodule
